// ----- rtl/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg
// shared types and fixed constants of the swing index calculator
// ----------------------------------------------------------------------------
package sic_pkg;

    // limit move register width
    localparam int LIMIT_WIDTH = 32;
    // result width, signed q32.16
    localparam int OUT_WIDTH   = 48;
    // quotient bits formed by the divider
    localparam int QUOT_WIDTH  = 48;
    // multiplier digit consumed per step
    localparam int DIGIT_WIDTH = 16;
    // 50 * 65536 = 25 << 17
    localparam int SCALE_SHIFT = 17;

    localparam logic [OUT_WIDTH-1:0] POS_BOUND = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] NEG_BOUND = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_CHK,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // classification of one bar, front to back
    typedef struct packed {
        logic first;   // no previous bar in this series
        logic zdiv;    // range or limit move is zero
        logic neg;     // numerator is negative
    } t_job_flags;

endpackage

// ----- rtl/sic_if.sv -----
// ----------------------------------------------------------------------------
// sic_if
// valid/ready channels of the swing index calculator: bars in, results out
// ----------------------------------------------------------------------------
interface sic_bar_if #(
    parameter int PRICE_WIDTH = 32
) ();
    logic                   valid;
    logic                   ready;
    logic                   series_start;
    logic [PRICE_WIDTH-1:0] open_price;
    logic [PRICE_WIDTH-1:0] high_price;
    logic [PRICE_WIDTH-1:0] low_price;
    logic [PRICE_WIDTH-1:0] close_price;

    modport source (
        output valid, series_start, open_price, high_price, low_price, close_price,
        input  ready
    );
    modport sink (
        input  valid, series_start, open_price, high_price, low_price, close_price,
        output ready
    );
endinterface

interface sic_res_if ();
    logic                                  valid;
    logic                                  ready;
    logic signed [sic_pkg::OUT_WIDTH-1:0]  swing_value;
    logic                                  value_valid;
    logic                                  zero_range;
    logic                                  saturated;

    modport source (
        output valid, swing_value, value_valid, zero_range, saturated,
        input  ready
    );
    modport sink (
        input  valid, swing_value, value_valid, zero_range, saturated,
        output ready
    );
endinterface

// ----- rtl/sic_fifo.sv -----
// ----------------------------------------------------------------------------
// sic_fifo
// short job queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module sic_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // writer and reader honor the flags
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full job queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty job queue");

endmodule

// ----- rtl/sic_front.sv -----
// ----------------------------------------------------------------------------
// sic_front
// takes bars, keeps the previous bar, forms k, and numerator and range in quarter ticks
// ----------------------------------------------------------------------------
module sic_front #(
    parameter int PRICE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    sic_bar_if.sink                              i_bar,
    input  logic [sic_pkg::LIMIT_WIDTH-1:0]      i_limit_move,
    output logic                                 o_push,
    input  logic                                 i_full,
    output sic_pkg::t_job_flags                  o_flags,
    output logic [PRICE_WIDTH+2:0]               o_num_mag,
    output logic [PRICE_WIDTH-1:0]               o_k,
    output logic [PRICE_WIDTH+2:0]               o_r4
);
    localparam int PW = PRICE_WIDTH;
    localparam int MW = PRICE_WIDTH + 3;
    localparam int SW = PRICE_WIDTH + 4;

    logic          r_hold_valid;
    logic          r_have_prev;
    logic [PW-1:0] r_prev_open;
    logic [PW-1:0] r_prev_close;
    logic          r_first;
    logic [PW-1:0] r_o, r_h, r_l, r_c, r_cy, r_oy;

    logic          accept;
    logic [PW:0]   d_hc, d_lc, d_hl, d_co, d_cc, d_c_o;
    logic [PW:0]   neg_hc, neg_lc, neg_hl, neg_co;
    logic [PW-1:0] hc, lc, hl, co;
    logic [SW-1:0] num4, num4_neg;
    logic [MW-1:0] hc_e, lc_e, hl_e, co_e, r4;

    assign i_bar.ready = !r_hold_valid || !i_full;
    assign accept      = i_bar.valid && i_bar.ready;
    assign o_push      = r_hold_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_have_prev  <= 1'b0;
            r_prev_open  <= '0;
            r_prev_close <= '0;
        end else if (accept) begin
            r_hold_valid <= 1'b1;
            r_have_prev  <= 1'b1;
            r_prev_open  <= i_bar.open_price;
            r_prev_close <= i_bar.close_price;
        end else if (o_push) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first <= i_bar.series_start || !r_have_prev;
            r_o     <= i_bar.open_price;
            r_h     <= i_bar.high_price;
            r_l     <= i_bar.low_price;
            r_c     <= i_bar.close_price;
            r_cy    <= r_prev_close;
            r_oy    <= r_prev_open;
        end
    end

    // differences, one guard bit for the sign
    always_comb begin
        d_hc   = {1'b0, r_h}  - {1'b0, r_cy};
        d_lc   = {1'b0, r_l}  - {1'b0, r_cy};
        d_hl   = {1'b0, r_h}  - {1'b0, r_l};
        d_co   = {1'b0, r_cy} - {1'b0, r_oy};
        d_cc   = {1'b0, r_c}  - {1'b0, r_cy};
        d_c_o  = {1'b0, r_c}  - {1'b0, r_o};
        neg_hc = ~d_hc + 1'b1;
        neg_lc = ~d_lc + 1'b1;
        neg_hl = ~d_hl + 1'b1;
        neg_co = ~d_co + 1'b1;
        hc     = d_hc[PW] ? neg_hc[PW-1:0] : d_hc[PW-1:0];
        lc     = d_lc[PW] ? neg_lc[PW-1:0] : d_lc[PW-1:0];
        hl     = d_hl[PW] ? neg_hl[PW-1:0] : d_hl[PW-1:0];
        co     = d_co[PW] ? neg_co[PW-1:0] : d_co[PW-1:0];
    end

    // 4(c-cy) + 2(c-o) + (cy-oy)
    always_comb begin
        num4 = ({{3{d_cc[PW]}}, d_cc} << 2)
             + ({{3{d_c_o[PW]}}, d_c_o} << 1)
             + {{3{d_co[PW]}}, d_co};
        num4_neg = ~num4 + 1'b1;
    end

    // range pick, ties go to the earlier case
    always_comb begin
        hc_e = MW'(hc);
        lc_e = MW'(lc);
        hl_e = MW'(hl);
        co_e = MW'(co);
        if (hc >= lc && hc >= hl) begin
            r4 = (hc_e << 2) - (lc_e << 1) + co_e;
        end else if (lc >= hc && lc >= hl) begin
            r4 = (lc_e << 2) - (hc_e << 1) + co_e;
        end else begin
            r4 = (hl_e << 2) + co_e;
        end
    end

    always_comb begin
        o_flags.first = r_first;
        o_flags.zdiv  = (r4 == '0) || (i_limit_move == '0);
        o_flags.neg   = num4[SW-1];
        o_num_mag     = num4[SW-1] ? num4_neg[MW-1:0] : num4[MW-1:0];
        o_k           = (hc >= lc) ? hc : lc;
        o_r4          = r4;
    end

endmodule

// ----- rtl/sic_back.sv -----
// ----------------------------------------------------------------------------
// sic_back
// digit-serial products, overflow check, restoring divide and result register
// ----------------------------------------------------------------------------
module sic_back #(
    parameter int PRICE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  sic_pkg::t_job_flags             i_flags,
    input  logic [PRICE_WIDTH+2:0]          i_num_mag,
    input  logic [PRICE_WIDTH-1:0]          i_k,
    input  logic [PRICE_WIDTH+2:0]          i_r4,
    input  logic [sic_pkg::LIMIT_WIDTH-1:0] i_limit_move,
    sic_res_if.source                       o_res
);
    localparam int PW  = PRICE_WIDTH;
    localparam int MW  = PRICE_WIDTH + 3;
    localparam int DW  = sic_pkg::DIGIT_WIDTH;
    localparam int QW  = sic_pkg::QUOT_WIDTH;
    localparam int OW  = sic_pkg::OUT_WIDTH;
    localparam int ND0 = (PW + DW - 1) / DW;
    localparam int ND1 = (sic_pkg::LIMIT_WIDTH + DW - 1) / DW;
    localparam int NS  = (ND0 > ND1) ? ND0 : ND1;
    localparam int OPW = NS * DW;
    localparam int AW  = MW + OPW;            // product width
    localparam int SW  = AW + 5;              // product times 25
    localparam int LOW = QW - sic_pkg::SCALE_SHIFT;
    localparam int HW  = SW - LOW;            // numerator bits above the quotient
    localparam int CW  = $clog2(QW);
    localparam logic [CW-1:0] MUL_LAST = CW'(NS - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

    sic_pkg::t_back_state r_state, n_state;

    logic [CW-1:0]       r_cnt;
    sic_pkg::t_job_flags r_flags;
    logic [MW-1:0]       r_num_mag;
    logic [MW-1:0]       r_r4;
    logic [OPW-1:0]      r_kd;
    logic [OPW-1:0]      r_ld;
    logic [AW-1:0]       r_acc;
    logic [AW-1:0]       r_den;
    logic [SW-1:0]       r_num25;
    logic [AW-1:0]       r_rem;
    logic [QW-1:0]       r_q;
    logic                r_ovf;

    logic                r_ovalid;
    logic [OW-1:0]       r_swing;
    logic                r_vv, r_zr, r_sat;

    logic                out_free;
    logic                load_job, step_mul, do_scale, do_chk, step_div, load_out;
    logic [MW+DW-1:0]    prod_a, prod_b;
    logic [HW-1:0]       num_hi;
    logic                ovf;
    logic [AW:0]         trial, diff;
    logic                ge;
    logic [OW-1:0]       bound, sat_mag, neg_mag;
    logic                sat;
    logic [OW-1:0]       res_swing;
    logic                res_vv, res_zr, res_sat;

    assign out_free = !r_ovalid || o_res.ready;

    // datapath terms
    always_comb begin
        prod_a = r_num_mag * r_kd[OPW-1 -: DW];
        prod_b = r_r4 * r_ld[OPW-1 -: DW];
        num_hi = r_num25[SW-1:LOW];
        ovf    = (AW'(num_hi) >= r_den);
        trial  = {r_rem, r_q[QW-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sic_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_flags.first || i_flags.zdiv) ? sic_pkg::BK_DONE
                                                              : sic_pkg::BK_MUL;
                end
            end
            sic_pkg::BK_MUL: begin
                if (r_cnt == MUL_LAST) n_state = sic_pkg::BK_SCALE;
            end
            sic_pkg::BK_SCALE: n_state = sic_pkg::BK_CHK;
            sic_pkg::BK_CHK: begin
                n_state = ovf ? sic_pkg::BK_DONE : sic_pkg::BK_DIV;
            end
            sic_pkg::BK_DIV: begin
                if (r_cnt == DIV_LAST) n_state = sic_pkg::BK_DONE;
            end
            sic_pkg::BK_DONE: begin
                if (out_free) n_state = sic_pkg::BK_IDLE;
            end
            default: n_state = sic_pkg::BK_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        load_job = 1'b0;
        step_mul = 1'b0;
        do_scale = 1'b0;
        do_chk   = 1'b0;
        step_div = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            sic_pkg::BK_IDLE:  load_job = !i_empty;
            sic_pkg::BK_MUL:   step_mul = 1'b1;
            sic_pkg::BK_SCALE: do_scale = 1'b1;
            sic_pkg::BK_CHK:   do_chk   = 1'b1;
            sic_pkg::BK_DIV:   step_div = 1'b1;
            sic_pkg::BK_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    assign o_pop = load_job;

    // final sign, saturation
    always_comb begin
        bound     = r_flags.neg ? sic_pkg::NEG_BOUND : sic_pkg::POS_BOUND;
        sat       = r_ovf || (r_q > bound);
        sat_mag   = sat ? bound : r_q;
        neg_mag   = ~sat_mag + 1'b1;
        res_swing = '0;
        res_vv    = 1'b1;
        res_zr    = 1'b0;
        res_sat   = 1'b0;
        if (r_flags.first) begin
            res_vv = 1'b0;
        end else if (r_flags.zdiv) begin
            res_zr = 1'b1;
        end else begin
            res_swing = r_flags.neg ? neg_mag : sat_mag;
            res_sat   = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sic_pkg::BK_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (step_mul || step_div) begin
                r_cnt <= (n_state == r_state) ? r_cnt + 1'b1 : '0;
            end else begin
                r_cnt <= '0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_flags   <= i_flags;
            r_num_mag <= i_num_mag;
            r_r4      <= i_r4;
            r_kd      <= OPW'(i_k);
            r_ld      <= OPW'(i_limit_move);
            r_acc     <= '0;
            r_den     <= '0;
        end
        if (step_mul) begin
            r_acc <= (r_acc << DW) + AW'(prod_a);
            r_den <= (r_den << DW) + AW'(prod_b);
            r_kd  <= r_kd << DW;
            r_ld  <= r_ld << DW;
        end
        if (do_scale) begin
            // times 25; the 2^17 lands in the split below
            r_num25 <= (SW'(r_acc) << 4) + (SW'(r_acc) << 3) + SW'(r_acc);
        end
        if (do_chk) begin
            r_ovf <= ovf;
            r_rem <= AW'(num_hi);
            r_q   <= {r_num25[LOW-1:0], {sic_pkg::SCALE_SHIFT{1'b0}}};
        end
        if (step_div) begin
            r_rem <= ge ? diff[AW-1:0] : trial[AW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
        if (load_out) begin
            r_swing <= res_swing;
            r_vv    <= res_vv;
            r_zr    <= res_zr;
            r_sat   <= res_sat;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.swing_value = r_swing;
    assign o_res.value_valid = r_vv;
    assign o_res.zero_range  = r_zr;
    assign o_res.saturated   = r_sat;

    // partial remainder stays below a nonzero divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sic_pkg::BK_DIV) |-> (r_den != '0) && (r_rem < r_den))
        else $error("divider remainder out of range");

endmodule

// ----- rtl/swing_index_calculator.sv -----
// ----------------------------------------------------------------------------
// swing_index_calculator
// wilder swing index per price bar, signed q32.16, saturated
// ----------------------------------------------------------------------------
// usage:
//   i_bar carries one bar per word (series_start, open, high, low, close in
//   ticks); o_res returns exactly one word per bar, in order.
//   i_cfg_we/i_cfg_wdata set limit_move; write it only while no bar is in flight
//   a first bar of a series gives value_valid = 0; on a later bar a zero range
//   or a zero limit move gives zero_range = 1 and a value of 0
// back end:
//   a bar with a value is multiplied one 16-bit digit at a time over NS digits,
//   NS being the number of 16-bit digits of the wider of price and limit move,
//   then scaled, checked and divided: the 48-step restoring divider sets the
//   pace, one bit a cycle; the back end works on one bar at a time
//   a quotient that overflows outright skips the divider
//   first-bar and zero-range words skip the products and the divider
// reset and stalls:
//   reset clears the previous bar, the queue and the output; limit_move goes to 1
//   a stalled receiver holds the result word; the front keeps taking bars into
//   its holding register and a two-entry job queue until both are full
// ----------------------------------------------------------------------------
module swing_index_calculator #(
    parameter int PRICE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sic_pkg::LIMIT_WIDTH-1:0] i_cfg_wdata,
    sic_bar_if.sink                         i_bar,
    sic_res_if.source                       o_res
);
    localparam int MW    = PRICE_WIDTH + 3;
    localparam int FW    = $bits(sic_pkg::t_job_flags);
    localparam int JOB_W = FW + MW + PRICE_WIDTH + MW;

    // configuration register
    logic [sic_pkg::LIMIT_WIDTH-1:0] r_limit_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_move <= sic_pkg::LIMIT_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_limit_move <= i_cfg_wdata;
        end
    end

    // front side job
    logic                   push;
    logic                   full;
    sic_pkg::t_job_flags    f_flags;
    logic [MW-1:0]          f_num_mag;
    logic [PRICE_WIDTH-1:0] f_k;
    logic [MW-1:0]          f_r4;

    // back side job
    logic                   pop;
    logic                   empty;
    sic_pkg::t_job_flags    b_flags;
    logic [MW-1:0]          b_num_mag;
    logic [PRICE_WIDTH-1:0] b_k;
    logic [MW-1:0]          b_r4;

    logic [JOB_W-1:0]       wr_job;
    logic [JOB_W-1:0]       rd_job;

    // classify: deltas against the previous bar, numerator, k, range
    sic_front #(
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bar        (i_bar),
        .i_limit_move (r_limit_move),
        .o_push       (push),
        .i_full       (full),
        .o_flags      (f_flags),
        .o_num_mag    (f_num_mag),
        .o_k          (f_k),
        .o_r4         (f_r4)
    );

    assign wr_job = {f_flags, f_num_mag, f_k, f_r4};

    // decouples bar intake from the long divide
    sic_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_job),
        .o_full    (full),
        .i_pop     (pop),
        .o_rd_data (rd_job),
        .o_empty   (empty)
    );

    assign {b_flags, b_num_mag, b_k, b_r4} = rd_job;

    // products, divide, saturate, output register
    sic_back #(
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_flags      (b_flags),
        .i_num_mag    (b_num_mag),
        .i_k          (b_k),
        .i_r4         (b_r4),
        .i_limit_move (r_limit_move),
        .o_res        (o_res)
    );

    // a not-valid word carries nothing else
    a_na_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.value_valid) |->
            (o_res.swing_value == '0) && !o_res.zero_range && !o_res.saturated)
        else $error("first-bar word carries value or flags");

    // zero range means no quotient, so no clipping
    a_zero_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_range) |->
            (o_res.swing_value == '0) && !o_res.saturated)
        else $error("zero-range word carries value or saturation");

endmodule
